[rtl/core/sia_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the shifting insert array unit.
// ----------------------------------------------------------------------------
package sia_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 7;
   localparam int FILL_W        = 7;
   localparam int EIDX_W        = 6;
   localparam int CAP_W         = 7;
   localparam int STS_W         = 3;
   localparam int FUNC_W        = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STS_W-1:0] {
      STS_DONE      = 3'd0,
      STS_RANGE     = 3'd1,
      STS_FULL      = 3'd2,
      STS_OVERWRITE = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   // what every cell does in the current cycle
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_APPEND,
      MODE_INSERT,
      MODE_OVERWRITE,
      MODE_ROTATE
   } mode_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_READ
   } state_type;

   // broadcast to all cells
   typedef struct packed {
      mode_type                 mode;
      logic [POS_W-1:0]         pos;
      logic [FILL_W-1:0]        fill;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

[rtl/core/sia_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sia_cell
// One array entry; loads, shifts up from its left neighbor, or rotates down.
// ----------------------------------------------------------------------------
module sia_cell #(
   parameter int IDX = 0
) (
   input  wire logic                          clock,
   input  wire sia_pkg::cell_ctrl_type        ctrl,
   input  wire logic signed [sia_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [sia_pkg::DATA_W-1:0] right_data,
   input  wire logic signed [sia_pkg::DATA_W-1:0] head_data,
   output logic signed [sia_pkg::DATA_W-1:0]      data_q
);
   import sia_pkg::*;

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.mode)
         MODE_APPEND: begin
            if (MY_IDX == ctrl.fill) data_in = ctrl.value;
         end
         MODE_INSERT: begin
            if (MY_IDX == ctrl.pos) begin
               data_in = ctrl.value;
            end else if (MY_IDX > ctrl.pos && MY_IDX <= ctrl.fill) begin
               data_in = left_data;
            end
         end
         MODE_OVERWRITE: begin
            if (MY_IDX == ctrl.pos) data_in = ctrl.value;
         end
         MODE_ROTATE: begin
            // top filled entry takes the head, the rest move down
            if (MY_IDX + POS_W'(1) == ctrl.fill) begin
               data_in = head_data;
            end else if (MY_IDX + POS_W'(1) < ctrl.fill) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule
`default_nettype wire

[rtl/core/shifting_insert_array_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shifting_insert_array_unit
// Dense array of signed words held in a chain of cells, with append,
// insert-with-shift and in-order read-out.
// ----------------------------------------------------------------------------
// Timing: append and insert give their word in the cycle after acceptance.
// A read-out enters the read state, then registers each entry from cell 0,
// one per cycle unless the response side stalls, as the chain rotates toward cell 0.
// Throughput: one append/insert per cycle unless the response side stalls;
// requests are held off during a read-out. An empty read-out gives one word.
// Reset: fill count cleared, capacity set to 64; entries are not cleared.
// ----------------------------------------------------------------------------
module shifting_insert_array_unit #(
   parameter int DEPTH = sia_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request word
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // [6:0] position, [38:7] value, [39] zero
   input  wire logic [1:0]  req_tuser,  // [1:0] func
   // response word
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // [31:0] data_out, [37:32] entry_index,
                                        // [44:38] fill_after, [47:45] zero
   output logic [2:0]       rsp_tuser,  // [2:0] status
   output logic             rsp_tlast,  // last
   // capacity register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data
);
   import sia_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(DEPTH);

   // request fields
   func_type                 req_func;
   logic [POS_W-1:0]         req_pos;
   logic signed [DATA_W-1:0] req_value;

   assign req_func  = func_type'(req_tuser);
   assign req_pos   = req_tdata[6:0];
   assign req_value = req_tdata[38:7];

   // control state
   state_type        state_ff,  state_in;
   logic [CNT_W-1:0] fill_ff,   fill_in;
   logic [IDX_W-1:0] rd_ff,     rd_in;
   logic [CAP_W-1:0] cap_ff;

   // response register
   logic                     rsp_valid_ff,  rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff,   rsp_data_in;
   logic [EIDX_W-1:0]        rsp_index_ff,  rsp_index_in;
   logic [FILL_W-1:0]        rsp_fill_ff,   rsp_fill_in;
   logic                     rsp_last_ff,   rsp_last_in;

   cell_ctrl_type            cell_ctrl;
   logic signed [DATA_W-1:0] cell_q [DEPTH];

   logic [CAP_W-1:0]  eff_cap;
   logic [FILL_W-1:0] fill_ext;
   logic              full;
   logic              out_free;
   logic              load;
   logic              rd_last;

   // clamp capacity into 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > DEPTH_FILL) begin
         eff_cap = DEPTH_FILL;
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign fill_ext = FILL_W'(fill_ff);
   assign full     = fill_ext >= eff_cap;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_last  = (CNT_W'(rd_ff) + CNT_W'(1)) == fill_ff;

   // next state, cell commands and response load
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_in         = rd_ff;
      req_tready    = 1'b0;
      load          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      cell_ctrl.mode  = MODE_IDLE;
      cell_ctrl.pos   = req_pos;
      cell_ctrl.fill  = fill_ext;
      cell_ctrl.value = req_value;

      case (state_ff)
         STATE_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               rsp_data_in  = '0;
               rsp_index_in = '0;
               rsp_last_in  = 1'b1;
               case (req_func)
                  FUNC_APPEND: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        cell_ctrl.mode = MODE_APPEND;
                        fill_in        = fill_ff + CNT_W'(1);
                        rsp_status_in  = STS_DONE;
                     end
                  end
                  FUNC_INSERT: begin
                     load = 1'b1;
                     if (req_pos > fill_ext) begin
                        rsp_status_in = STS_RANGE;
                     end else if (full) begin
                        // full: overwrite in place, nothing to overwrite at the end
                        if (req_pos < fill_ext) begin
                           cell_ctrl.mode = MODE_OVERWRITE;
                           rsp_status_in  = STS_OVERWRITE;
                        end else begin
                           rsp_status_in = STS_FULL;
                        end
                     end else begin
                        cell_ctrl.mode = MODE_INSERT;
                        fill_in        = fill_ff + CNT_W'(1);
                        rsp_status_in  = STS_DONE;
                     end
                  end
                  FUNC_READ: begin
                     if (fill_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        state_in = STATE_READ;
                        rd_in    = '0;
                     end
                  end
                  default: begin
                     // unused selector: dropped
                  end
               endcase
            end
         end
         STATE_READ: begin
            if (out_free) begin
               // cell 0 holds entry rd_ff; rotate so the next one arrives there
               load           = 1'b1;
               cell_ctrl.mode = MODE_ROTATE;
               rsp_status_in  = STS_DONE;
               rsp_data_in    = cell_q[0];
               rsp_index_in   = EIDX_W'(rd_ff);
               rsp_last_in    = rd_last;
               if (rd_last) begin
                  state_in = STATE_IDLE;
               end else begin
                  rd_in = rd_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = STATE_IDLE;
      endcase

      if (load) rsp_valid_in = 1'b1;
      rsp_fill_in = load ? FILL_W'(fill_in) : rsp_fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         fill_ff      <= '0;
         rd_ff        <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) cap_ff <= csr_data;
      end
   end

   // response payload, no reset
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // chain of cells; end cells see zero beyond the chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;

      if (g == 0) begin : g_lo
         assign left_d = '0;
      end else begin : g_lo
         assign left_d = cell_q[g-1];
      end

      if (g == DEPTH - 1) begin : g_hi
         assign right_d = '0;
      end else begin : g_hi
         assign right_d = cell_q[g+1];
      end

      sia_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_q[0]),
         .data_q     (cell_q[g])
      );
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_fill_ff, rsp_index_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

[rtl/core/sia_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks for the shifting insert array unit.
// ----------------------------------------------------------------------------
module sia_checker #(
   parameter int DEPTH = sia_pkg::DEPTH_DEFAULT
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import sia_pkg::*;

   // no response word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // every status but done is a single-word result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STS_DONE |-> rsp_tlast && rsp_tdata[37:0] == '0)
      else $error("non-done status not a lone word");

   // empty read-out reports zero fill
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_EMPTY |-> rsp_tdata[44:38] == '0)
      else $error("empty status with nonzero fill");

   // fill never exceeds the built depth
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[44:38] <= FILL_W'(DEPTH))
      else $error("fill above depth");

endmodule

bind shifting_insert_array_unit sia_checker #(.DEPTH(DEPTH)) u_sia_checker (.*);
`default_nettype wire

[verif/shifting_insert_array_unit_tb.sv]
// ----------------------------------------------------------------------------
// shifting_insert_array_unit_tb
// Self-checking bench for the shifting insert array unit. A driver block
// plays request words from a backlog queue. A shadow array predicts the
// response words of each accepted request. A monitor block compares every
// response word, field by field, with the oldest prediction. Both stream
// sides idle and stall at random, and the capacity register is rewritten
// between phases while the unit is quiet.
// ----------------------------------------------------------------------------
module shifting_insert_array_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sia_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int SIDX_W      = $clog2(DEPTH);
   localparam int SETTLE_CYC  = 80;         // longer than the longest read-out
   localparam int CYCLE_LIMIT = 2_000_000;

   // one request as the sender sees it
   typedef struct {
      func_type                 func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   // one response word, unpacked
   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data_out;
      logic [EIDX_W-1:0]        entry_index;
      logic [FILL_W-1:0]        fill_after;
      logic                     last;
   } rsp_word_type;

   // -------------------------------------------------------------------------
   // clock, reset, DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [6:0] position, [38:7] value, [39] zero
   logic [1:0]  req_tuser  = '0;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [31:0] data_out, [37:32] entry_index,
                                   // [44:38] fill_after, [47:45] zero
   logic [2:0]  rsp_tuser;         // [2:0] status
   logic        rsp_tlast;         // last
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data   = '0;

   shifting_insert_array_unit #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // bench state
   // -------------------------------------------------------------------------
   req_item_type   req_backlog[$];      // requests not yet put on the bus
   rsp_word_type   predicted_rsps[$];   // response words still owed by the DUT

   // shadow array, updated at request acceptance
   logic signed [DATA_W-1:0] shadow_store [DEPTH];
   int unsigned              shadow_fill     = 0;
   logic [CAP_W-1:0]         shadow_capacity = CAP_RESET;

   // stimulus-side fill estimate, used only to aim insert positions
   int unsigned      gen_fill     = 0;
   logic [CAP_W-1:0] gen_capacity = CAP_RESET;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatch_count     = 0;
   int unsigned cycle_count        = 0;

   // -------------------------------------------------------------------------
   // helpers
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("mismatch @ cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // capacity register is clamped into 1..DEPTH
   function automatic int unsigned eff_capacity(input logic [CAP_W-1:0] cap);
      if (cap == 0) return 1;
      if (cap > DEPTH) return DEPTH;
      return cap;
   endfunction

   // Shadow of the unit: apply one accepted request, queue its response words.
   task automatic apply_array_op(input req_item_type it);
      rsp_word_type w;
      int unsigned  cap;
      logic         full;
      cap  = eff_capacity(shadow_capacity);
      full = (shadow_fill >= cap);
      w.status      = STS_DONE;
      w.data_out    = '0;
      w.entry_index = '0;
      w.last        = 1'b1;
      case (it.func)
         FUNC_APPEND: begin
            if (full) begin
               w.status = STS_FULL;
            end else begin
               shadow_store[SIDX_W'(shadow_fill)] = it.value;
               shadow_fill++;
            end
            w.fill_after = shadow_fill[FILL_W-1:0];
            predicted_rsps.push_back(w);
         end
         FUNC_INSERT: begin
            if (it.position > shadow_fill) begin
               w.status = STS_RANGE;
            end else if (full) begin
               // full: overwrite in place, nothing to overwrite at the end
               if (it.position < shadow_fill) begin
                  shadow_store[SIDX_W'(it.position)] = it.value;
                  w.status = STS_OVERWRITE;
               end else begin
                  w.status = STS_FULL;
               end
            end else begin
               for (int i = shadow_fill; i > it.position; i--)
                  shadow_store[SIDX_W'(i)] = shadow_store[SIDX_W'(i-1)];
               shadow_store[SIDX_W'(it.position)] = it.value;
               shadow_fill++;
            end
            w.fill_after = shadow_fill[FILL_W-1:0];
            predicted_rsps.push_back(w);
         end
         FUNC_READ: begin
            w.fill_after = shadow_fill[FILL_W-1:0];
            if (shadow_fill == 0) begin
               w.status = STS_EMPTY;
               predicted_rsps.push_back(w);
            end else begin
               for (int i = 0; i < shadow_fill; i++) begin
                  w.data_out    = shadow_store[SIDX_W'(i)];
                  w.entry_index = i[EIDX_W-1:0];
                  w.last        = (i + 1 == shadow_fill);
                  predicted_rsps.push_back(w);
               end
            end
         end
         default: ;   // unused selector: no words, no change
      endcase
   endtask

   task automatic queue_item(input func_type f, input int unsigned pos,
                             input logic [DATA_W-1:0] val);
      req_item_type it;
      int unsigned  cap;
      it.func     = f;
      it.position = pos[POS_W-1:0];
      it.value    = val;
      req_backlog.push_back(it);
      cap = eff_capacity(gen_capacity);
      if (gen_fill < cap &&
          (f == FUNC_APPEND || (f == FUNC_INSERT && pos <= gen_fill)))
         gen_fill++;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_random_item();
      func_type    f;
      int unsigned pos;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 35)      f = FUNC_APPEND;
      else if (sel < 80) f = FUNC_INSERT;
      else if (sel < 92) f = FUNC_READ;
      else               f = FUNC_NONE;
      // mostly legal insert positions, some at the end, some anywhere
      sel = $urandom_range(0, 9);
      if (sel < 7)       pos = $urandom_range(0, gen_fill);
      else if (sel < 8)  pos = gen_fill;
      else               pos = $urandom_range(0, DEPTH);
      queue_item(f, pos, pick_value());
   endtask

   // wait until the bus is drained and every owed word has arrived
   task automatic settle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || predicted_rsps.size() != 0)
         @(negedge clock);
      // an ignored request or a read-out tail may still be in flight
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // capacity write, only while the unit is quiet
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      shadow_capacity  = cap;
      gen_capacity     = cap;
      @(negedge clock);
   endtask

   task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int count,
                                   input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      write_capacity(cap);
      repeat (count) queue_random_item();
      settle();
   endtask

   // -------------------------------------------------------------------------
   // driver: request side
   // -------------------------------------------------------------------------
   req_item_type on_bus;        // word currently offered on req_*
   int unsigned  send_gap = 0;  // remaining cycles of an idle burst

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap    = 0;
      end else begin
         if (req_tvalid && req_tready)
            apply_array_op(on_bus);
         // a word offered and not yet taken stays put
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if ($urandom_range(0, 99) < sender_idle_pct) begin
               send_gap    = $urandom_range(1, 16) - 1;
               req_tvalid <= 1'b0;
            end else begin
               on_bus      = req_backlog.pop_front();
               req_tdata  <= {1'b0, on_bus.value, on_bus.position};
               req_tuser  <= on_bus.func;
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // monitor: response side
   // -------------------------------------------------------------------------
   int unsigned stall_left = 0;

   always @(posedge clock) begin : rsp_mon
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = status_type'(rsp_tuser);
            got.data_out    = rsp_tdata[31:0];
            got.entry_index = rsp_tdata[37:32];
            got.fill_after  = rsp_tdata[44:38];
            got.last        = rsp_tlast;
            if (predicted_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected word status=%0d data=%0d",
                                         got.status, got.data_out));
            end else begin
               want = predicted_rsps.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            got.status, want.status));
               if (got.data_out !== want.data_out)
                  report_mismatch($sformatf("data_out %0d, want %0d",
                                            got.data_out, want.data_out));
               if (got.entry_index !== want.entry_index)
                  report_mismatch($sformatf("entry_index %0d, want %0d",
                                            got.entry_index, want.entry_index));
               if (got.fill_after !== want.fill_after)
                  report_mismatch($sformatf("fill_after %0d, want %0d",
                                            got.fill_after, want.fill_after));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b",
                                            got.last, want.last));
            end
         end
         // back-pressure in bursts
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < receiver_stall_pct) begin
            stall_left  = $urandom_range(1, 16) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct    = 30;
      receiver_stall_pct = 30;

      // small capacity: empty read, range checks, shifts, full behavior
      write_capacity(7'd4);
      queue_item(FUNC_READ,   0, 32'h0);            // empty read-out
      queue_item(FUNC_INSERT, 1, 32'h1);            // above fill on empty
      queue_item(FUNC_INSERT, 0, 32'h8000_0000);    // insert into empty
      queue_item(FUNC_APPEND, 0, 32'h7FFF_FFFF);
      queue_item(FUNC_APPEND, 64, 32'h0);
      queue_item(FUNC_INSERT, 1, 32'hFFFF_FFFF);    // shift up, now full
      queue_item(FUNC_APPEND, 0, 32'h5);            // append when full
      queue_item(FUNC_INSERT, 4, 32'h6);            // at fill when full
      queue_item(FUNC_INSERT, 2, 32'h1234_5678);    // overwrite when full
      queue_item(FUNC_INSERT, 5, 32'h7);            // one past fill
      queue_item(FUNC_INSERT, 64, 32'h8);           // far out of range
      queue_item(FUNC_NONE,   63, 32'hDEAD_BEEF);   // unused selector
      queue_item(FUNC_READ,   0, 32'h0);
      settle();

      // capacity lowered under the fill count: counts as full, entries kept
      write_capacity(7'd2);
      queue_item(FUNC_APPEND, 0, 32'h9);
      queue_item(FUNC_INSERT, 0, 32'h5555_5555);
      queue_item(FUNC_READ,   0, 32'h0);
      settle();

      write_capacity(7'd1);
      queue_item(FUNC_INSERT, 3, 32'hAAAA_AAAA);
      settle();

      // zero clamps to one
      write_capacity(7'd0);
      queue_item(FUNC_APPEND, 0, 32'h1);
      queue_item(FUNC_READ,   0, 32'h0);
      settle();

      // random phases; fill only grows, so capacities climb, drop, then climb again
      run_random_phase(7'd20,  110, 20, 20);
      run_random_phase(7'd100, 130, 40, 10);   // clamps to DEPTH
      run_random_phase(7'd33,  100, 10, 40);   // below the fill count
      run_random_phase(7'd64,  100, 0, 0);     // no idling at the tail

      if (predicted_rsps.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", predicted_rsps.size()));
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/sia_pkg.sv
rtl/core/sia_cell.sv
rtl/core/shifting_insert_array_unit.sv
rtl/core/sia_checker.sv
verif/shifting_insert_array_unit_tb.sv
